/* design/gnlm_pkg.sv */
// Types, codes and constants shared by the gated nearest landmark match block.
package gnlm_pkg;

    localparam int ACC_W   = 66;
    localparam int PROD_W  = 64;
    localparam int WORLD_W = 36;
    localparam int DELTA_W = 37;

    localparam logic [30:0]         MAX_DIST     = 31'h7FFF_FFFF;
    localparam logic signed [33:0]  PI_Q30       = 34'sd3373259426;
    localparam logic signed [33:0]  HALF_PI_Q30  = 34'sd1686629713;
    localparam logic signed [32:0]  CORDIC_X0    = 33'sd652032874;
    localparam logic [30:0]         MAP_GATE_RST = 31'd164;
    localparam logic [30:0]         LMK_GATE_RST = 31'd23593;

    typedef enum logic [1:0] {
        KIND_MAP_WR = 2'd0,
        KIND_LMK_WR = 2'd1,
        KIND_QUERY  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CLASS_MAP = 2'd0,
        CLASS_LMK = 2'd1,
        CLASS_NEW = 2'd2
    } class_t;

    typedef enum logic [1:0] {
        CFG_MAP_COUNT = 2'd0,
        CFG_LMK_COUNT = 2'd1,
        CFG_MAP_GATE  = 2'd2,
        CFG_LMK_GATE  = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_ROT,
        ST_MAP_RD,
        ST_MAP_DELTA,
        ST_MAP_MAC,
        ST_MAP_CMP,
        ST_MAP_GATE,
        ST_LMK_RD,
        ST_LMK_DELTA,
        ST_LMK_MAC,
        ST_LMK_CMP,
        ST_LMK_GATE,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef struct packed {
        logic signed [31:0] op_a;
        logic signed [31:0] op_b;
        acc_op_t            acc_op;
    } mac_ctl_t;

    // atan(2^-i) in Q2.30, floored
    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'd843314856;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043836;
            5'd3:  v = 30'd133525158;
            5'd4:  v = 30'd67021686;
            5'd5:  v = 30'd33543515;
            5'd6:  v = 30'd16775850;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194282;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048575;
            5'd11: v = 30'd524287;
            5'd12: v = 30'd262143;
            5'd13: v = 30'd131071;
            5'd14: v = 30'd65535;
            5'd15: v = 30'd32767;
            5'd16: v = 30'd16383;
            5'd17: v = 30'd8191;
            5'd18: v = 30'd4095;
            5'd19: v = 30'd2047;
            5'd20: v = 30'd1023;
            5'd21: v = 30'd511;
            5'd22: v = 30'd255;
            5'd23: v = 30'd127;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

/* design/gnlm_mac.sv */
// Shared 32x32 signed multiplier with registered product and accumulator.
module gnlm_mac (
    input  logic                               aclk,
    input  gnlm_pkg::mac_ctl_t                 ctl,
    output logic signed [gnlm_pkg::ACC_W-1:0]  acc
);
    import gnlm_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    // acc_op acts on the product issued in the previous cycle
    always_ff @(posedge aclk) begin
        prod_reg <= ctl.op_a * ctl.op_b;
        case (ctl.acc_op)
            ACC_LOAD: acc_reg <= ACC_W'(prod_reg);
            ACC_ADD:  acc_reg <= acc_reg + ACC_W'(prod_reg);
            ACC_SUB:  acc_reg <= acc_reg - ACC_W'(prod_reg);
            default:  acc_reg <= acc_reg;
        endcase
    end

    assign acc = acc_reg;

endmodule

/* design/gated_nearest_landmark_match.sv */
// Gated nearest neighbour matcher: map/landmark tables, CORDIC and search sequencer.
//
// Input words arrive on s_tvalid/s_tready/s_tdata/s_tuser; s_tuser holds the kind.
// A map or landmark write gives no result. A query rotates the
// observed point into the world frame, scans the prior map with a weighted
// quadratic distance and, failing its gate, scans the landmark table with a
// Euclidean distance. One result word per query leaves on m_tvalid/m_tready.
// Every multiply goes through one shared 32x32 multiply-accumulate unit. s_tready
// is low while a query runs. The result sits in an output register; while the
// receiver stalls the block still takes the next word, and a second finished
// query holds in its last state, with s_tready low, until the register is free.
// Configuration writes on cfg_valid/cfg_index/cfg_data are always taken.
// Reset (aresetn low, synchronous) clears the sequencer, the output valid and the
// registers to their defaults; table contents are undefined until written.
module gated_nearest_landmark_match #(
    parameter int MAP_SLOTS      = 64,
    parameter int LANDMARK_SLOTS = 64,
    parameter int CORDIC_STEPS   = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // slot[5:0], coord_x, coord_y, weight_a..d, pose_x, pose_y, pose_heading[277:262]
    input  logic [279:0]  s_tdata,
    // kind[1:0]
    input  logic [1:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // match_index[5:0], best_distance_sq[36:6]
    output logic [39:0]   m_tdata,
    // match_class[1:0]
    output logic [1:0]    m_tuser,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [30:0]   cfg_data
);
    import gnlm_pkg::*;

    localparam int MAP_AW = (MAP_SLOTS > 1) ? $clog2(MAP_SLOTS) : 1;
    localparam int LMK_AW = (LANDMARK_SLOTS > 1) ? $clog2(LANDMARK_SLOTS) : 1;
    localparam int CNT_W  = $clog2(CORDIC_STEPS);

    // input fields
    logic [1:0]         in_kind;
    logic [5:0]         in_slot;
    logic signed [31:0] in_x, in_y, in_a, in_b, in_c, in_d, in_px, in_py;
    logic signed [15:0] in_heading;

    assign in_kind    = s_tuser;
    assign in_slot    = s_tdata[5:0];
    assign in_x       = s_tdata[37:6];
    assign in_y       = s_tdata[69:38];
    assign in_a       = s_tdata[101:70];
    assign in_b       = s_tdata[133:102];
    assign in_c       = s_tdata[165:134];
    assign in_d       = s_tdata[197:166];
    assign in_px      = s_tdata[229:198];
    assign in_py      = s_tdata[261:230];
    assign in_heading = s_tdata[277:262];

    // configuration
    logic [6:0]  map_count_reg, lmk_count_reg;
    logic [30:0] map_gate_reg, lmk_gate_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_count_reg <= '0;
            lmk_count_reg <= '0;
            map_gate_reg  <= MAP_GATE_RST;
            lmk_gate_reg  <= LMK_GATE_RST;
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_MAP_COUNT: map_count_reg <= cfg_data[6:0];
                CFG_LMK_COUNT: lmk_count_reg <= cfg_data[6:0];
                CFG_MAP_GATE:  map_gate_reg  <= cfg_data;
                CFG_LMK_GATE:  lmk_gate_reg  <= cfg_data;
                default:       map_count_reg <= map_count_reg;
            endcase
        end
    end

    logic [6:0] n_map, n_lmk;
    assign n_map = (32'(map_count_reg) > MAP_SLOTS) ? 7'(MAP_SLOTS) : map_count_reg;
    assign n_lmk = (32'(lmk_count_reg) > LANDMARK_SLOTS) ? 7'(LANDMARK_SLOTS) : lmk_count_reg;

    // sequencer state
    state_t             state_reg, state_next;
    logic [2:0]         u_reg, u_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [6:0]         idx_reg, idx_next;
    logic [30:0]        best_reg, best_next;
    logic [5:0]         best_idx_reg, best_idx_next;
    logic [1:0]         res_class_reg, res_class_next;
    logic [5:0]         res_index_reg, res_index_next;
    logic [30:0]        res_dist_reg, res_dist_next;
    logic               m_valid_reg, m_valid_next;
    logic [1:0]         out_class_reg;
    logic [5:0]         out_index_reg;
    logic [30:0]        out_dist_reg;

    // datapath registers
    logic signed [33:0]        z_reg;
    logic signed [32:0]        cx_reg, cy_reg;
    logic                      neg_reg;
    logic signed [31:0]        cs_reg, sn_reg, ox_reg, oy_reg, px_reg, py_reg;
    logic signed [WORLD_W-1:0] wx_reg, wy_reg;
    logic signed [DELTA_W-1:0] dx_reg, dy_reg;
    logic                      oor_reg;
    logic signed [31:0]        t0_reg, t1_reg;
    logic [63:0]               mpos_rd_reg, mtop_rd_reg, mbot_rd_reg, lpos_rd_reg;

    // tables
    logic [63:0] map_pos_mem [MAP_SLOTS];
    logic [63:0] map_top_mem [MAP_SLOTS];
    logic [63:0] map_bot_mem [MAP_SLOTS];
    logic [63:0] lmk_pos_mem [LANDMARK_SLOTS];

    logic accept_in, map_wr, lmk_wr, map_rd, lmk_rd;
    logic is_query;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept_in = s_tvalid && s_tready;
    assign map_wr    = accept_in && (in_kind == KIND_MAP_WR) && (32'(in_slot) < MAP_SLOTS);
    assign lmk_wr    = accept_in && (in_kind == KIND_LMK_WR) &&
                       (32'(in_slot) < LANDMARK_SLOTS);
    assign is_query  = accept_in && (in_kind == KIND_QUERY);
    assign map_rd    = (state_reg == ST_MAP_RD);
    assign lmk_rd    = (state_reg == ST_LMK_RD);

    always_ff @(posedge aclk) begin
        if (map_wr) begin
            map_pos_mem[MAP_AW'(in_slot)] <= {in_y, in_x};
            map_top_mem[MAP_AW'(in_slot)] <= {in_b, in_a};
            map_bot_mem[MAP_AW'(in_slot)] <= {in_d, in_c};
        end
        if (map_rd) begin
            mpos_rd_reg <= map_pos_mem[MAP_AW'(idx_reg)];
            mtop_rd_reg <= map_top_mem[MAP_AW'(idx_reg)];
            mbot_rd_reg <= map_bot_mem[MAP_AW'(idx_reg)];
        end
    end

    always_ff @(posedge aclk) begin
        if (lmk_wr)
            lmk_pos_mem[LMK_AW'(in_slot)] <= {in_y, in_x};
        if (lmk_rd)
            lpos_rd_reg <= lmk_pos_mem[LMK_AW'(idx_reg)];
    end

    // shared multiply-accumulate
    mac_ctl_t                mac_ctl;
    logic signed [ACC_W-1:0] acc;

    gnlm_mac u_mac (
        .aclk (aclk),
        .ctl  (mac_ctl),
        .acc  (acc)
    );

    // CORDIC step and query set-up
    logic signed [33:0] z_raw, at_step;
    logic signed [32:0] sx, sy;

    assign z_raw   = {in_heading[15], in_heading, 17'b0};
    assign at_step = signed'({4'b0, atan_q30(5'(cnt_reg))});
    assign sx      = cy_reg >>> cnt_reg;
    assign sy      = cx_reg >>> cnt_reg;

    // distances
    logic signed [DELTA_W-1:0] dx_calc, dy_calc;
    logic                      oor_calc;
    logic signed [49:0]        acc_q16;
    logic signed [31:0]        sat_q16;
    logic [30:0]               map_dist, lmk_dist;

    always_comb begin
        if (state_reg == ST_MAP_DELTA) begin
            dx_calc = DELTA_W'(signed'(mpos_rd_reg[31:0])) - DELTA_W'(wx_reg);
            dy_calc = DELTA_W'(signed'(mpos_rd_reg[63:32])) - DELTA_W'(wy_reg);
        end else begin
            dx_calc = DELTA_W'(wx_reg) - DELTA_W'(signed'(lpos_rd_reg[31:0]));
            dy_calc = DELTA_W'(wy_reg) - DELTA_W'(signed'(lpos_rd_reg[63:32]));
        end
    end

    assign oor_calc = (dx_calc >  DELTA_W'(signed'({1'b0, MAX_DIST}))) ||
                      (dx_calc < -DELTA_W'(signed'({1'b0, MAX_DIST}))) ||
                      (dy_calc >  DELTA_W'(signed'({1'b0, MAX_DIST}))) ||
                      (dy_calc < -DELTA_W'(signed'({1'b0, MAX_DIST})));

    assign acc_q16 = acc[ACC_W-1:16];

    always_comb begin
        if (acc_q16 > 50'(signed'({1'b0, MAX_DIST})))
            sat_q16 = signed'({1'b0, MAX_DIST});
        else if (acc_q16 < -50'(signed'({1'b0, MAX_DIST})))
            sat_q16 = -signed'({1'b0, MAX_DIST});
        else
            sat_q16 = acc_q16[31:0];
    end

    // a negative weighted distance never matches
    assign map_dist = (oor_reg || acc_q16 < 0 || acc_q16 > 50'(signed'({1'b0, MAX_DIST})))
                      ? MAX_DIST : acc_q16[30:0];
    assign lmk_dist = (oor_reg || acc_q16 > 50'(signed'({1'b0, MAX_DIST})))
                      ? MAX_DIST : acc_q16[30:0];

    logic signed [31:0] dx32, dy32;
    assign dx32 = dx_reg[31:0];
    assign dy32 = dy_reg[31:0];

    // sequencer
    always_comb begin
        state_next     = state_reg;
        u_next         = u_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        res_class_next = res_class_reg;
        res_index_next = res_index_reg;
        res_dist_next  = res_dist_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        mac_ctl.op_a   = '0;
        mac_ctl.op_b   = '0;
        mac_ctl.acc_op = ACC_HOLD;

        case (state_reg)
            ST_IDLE: begin
                if (is_query) begin
                    state_next = ST_CORDIC;
                    cnt_next   = '0;
                end
            end
            ST_CORDIC: begin
                cnt_next = cnt_reg + 1'b1;
                if (32'(cnt_reg) == CORDIC_STEPS - 1) begin
                    state_next = ST_ROT;
                    u_next     = '0;
                end
            end
            ST_ROT: begin
                u_next = u_reg + 3'd1;
                case (u_reg)
                    3'd1: begin
                        mac_ctl.op_a = ox_reg;
                        mac_ctl.op_b = cs_reg;
                    end
                    3'd2: begin
                        mac_ctl.op_a   = oy_reg;
                        mac_ctl.op_b   = sn_reg;
                        mac_ctl.acc_op = ACC_LOAD;
                    end
                    3'd3: begin
                        mac_ctl.op_a   = ox_reg;
                        mac_ctl.op_b   = sn_reg;
                        mac_ctl.acc_op = ACC_SUB;
                    end
                    3'd4: begin
                        mac_ctl.op_a   = oy_reg;
                        mac_ctl.op_b   = cs_reg;
                        mac_ctl.acc_op = ACC_LOAD;
                    end
                    3'd5: mac_ctl.acc_op = ACC_ADD;
                    3'd6: begin
                        idx_next      = '0;
                        best_next     = MAX_DIST;
                        best_idx_next = '0;
                        if (n_map != 7'd0)
                            state_next = ST_MAP_RD;
                        else if (n_lmk != 7'd0)
                            state_next = ST_LMK_RD;
                        else begin
                            res_class_next = CLASS_NEW;
                            res_index_next = '0;
                            res_dist_next  = '0;
                            state_next     = ST_DONE;
                        end
                    end
                    default: ;
                endcase
            end
            ST_MAP_RD:    state_next = ST_MAP_DELTA;
            ST_MAP_DELTA: begin
                state_next = ST_MAP_MAC;
                u_next     = '0;
            end
            ST_MAP_MAC: begin
                u_next = u_reg + 3'd1;
                case (u_reg)
                    3'd0: begin
                        mac_ctl.op_a = signed'(mtop_rd_reg[31:0]);
                        mac_ctl.op_b = dx32;
                    end
                    3'd1: begin
                        mac_ctl.op_a   = signed'(mbot_rd_reg[31:0]);
                        mac_ctl.op_b   = dy32;
                        mac_ctl.acc_op = ACC_LOAD;
                    end
                    3'd2: begin
                        mac_ctl.op_a   = signed'(mtop_rd_reg[63:32]);
                        mac_ctl.op_b   = dx32;
                        mac_ctl.acc_op = ACC_ADD;
                    end
                    3'd3: begin
                        mac_ctl.op_a   = signed'(mbot_rd_reg[63:32]);
                        mac_ctl.op_b   = dy32;
                        mac_ctl.acc_op = ACC_LOAD;
                    end
                    3'd4: begin
                        mac_ctl.op_a   = dx32;
                        mac_ctl.op_b   = t0_reg;
                        mac_ctl.acc_op = ACC_ADD;
                    end
                    3'd5: mac_ctl.acc_op = ACC_LOAD;
                    3'd6: begin
                        mac_ctl.op_a = dy32;
                        mac_ctl.op_b = t1_reg;
                    end
                    default: begin
                        mac_ctl.acc_op = ACC_ADD;
                        state_next     = ST_MAP_CMP;
                    end
                endcase
            end
            ST_MAP_CMP: begin
                if (map_dist < best_reg) begin
                    best_next     = map_dist;
                    best_idx_next = idx_reg[5:0];
                end
                idx_next = idx_reg + 7'd1;
                if (idx_reg + 7'd1 == n_map)
                    state_next = ST_MAP_GATE;
                else
                    state_next = ST_MAP_RD;
            end
            ST_MAP_GATE: begin
                idx_next      = '0;
                best_next     = MAX_DIST;
                best_idx_next = '0;
                if (best_reg < map_gate_reg) begin
                    res_class_next = CLASS_MAP;
                    res_index_next = best_idx_reg;
                    res_dist_next  = best_reg;
                    state_next     = ST_DONE;
                end else if (n_lmk != 7'd0)
                    state_next = ST_LMK_RD;
                else begin
                    res_class_next = CLASS_NEW;
                    res_index_next = '0;
                    res_dist_next  = '0;
                    state_next     = ST_DONE;
                end
            end
            ST_LMK_RD:    state_next = ST_LMK_DELTA;
            ST_LMK_DELTA: begin
                state_next = ST_LMK_MAC;
                u_next     = '0;
            end
            ST_LMK_MAC: begin
                u_next = u_reg + 3'd1;
                case (u_reg)
                    3'd0: begin
                        mac_ctl.op_a = dx32;
                        mac_ctl.op_b = dx32;
                    end
                    3'd1: begin
                        mac_ctl.op_a   = dy32;
                        mac_ctl.op_b   = dy32;
                        mac_ctl.acc_op = ACC_LOAD;
                    end
                    default: begin
                        mac_ctl.acc_op = ACC_ADD;
                        state_next     = ST_LMK_CMP;
                    end
                endcase
            end
            ST_LMK_CMP: begin
                if (lmk_dist < best_reg) begin
                    best_next     = lmk_dist;
                    best_idx_next = idx_reg[5:0];
                end
                idx_next = idx_reg + 7'd1;
                if (idx_reg + 7'd1 == n_lmk)
                    state_next = ST_LMK_GATE;
                else
                    state_next = ST_LMK_RD;
            end
            ST_LMK_GATE: begin
                state_next = ST_DONE;
                if (best_reg < lmk_gate_reg) begin
                    res_class_next = CLASS_LMK;
                    res_index_next = best_idx_reg;
                    res_dist_next  = best_reg;
                end else begin
                    res_class_next = CLASS_NEW;
                    res_index_next = '0;
                    res_dist_next  = '0;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            u_reg       <= '0;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            u_reg       <= u_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        best_reg      <= best_next;
        best_idx_reg  <= best_idx_next;
        res_class_reg <= res_class_next;
        res_index_reg <= res_index_next;
        res_dist_reg  <= res_dist_next;
        if (state_reg == ST_DONE && (!m_valid_reg || m_tready)) begin
            out_class_reg <= res_class_reg;
            out_index_reg <= res_index_reg;
            out_dist_reg  <= res_dist_reg;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (is_query) begin
            ox_reg <= in_x;
            oy_reg <= in_y;
            px_reg <= in_px;
            py_reg <= in_py;
            cx_reg <= CORDIC_X0;
            cy_reg <= '0;
            // fold into the right half plane, flip the result back later
            if (z_raw > HALF_PI_Q30) begin
                z_reg   <= z_raw - PI_Q30;
                neg_reg <= 1'b1;
            end else if (z_raw < -HALF_PI_Q30) begin
                z_reg   <= z_raw + PI_Q30;
                neg_reg <= 1'b1;
            end else begin
                z_reg   <= z_raw;
                neg_reg <= 1'b0;
            end
        end
        if (state_reg == ST_CORDIC) begin
            if (z_reg >= 0) begin
                cx_reg <= cx_reg - sx;
                cy_reg <= cy_reg + sy;
                z_reg  <= z_reg - at_step;
            end else begin
                cx_reg <= cx_reg + sx;
                cy_reg <= cy_reg - sy;
                z_reg  <= z_reg + at_step;
            end
        end
        if (state_reg == ST_ROT && u_reg == 3'd0) begin
            cs_reg <= neg_reg ? -cx_reg[31:0] : cx_reg[31:0];
            sn_reg <= neg_reg ? -cy_reg[31:0] : cy_reg[31:0];
        end
        if (state_reg == ST_ROT && u_reg == 3'd4)
            wx_reg <= acc[ACC_W-1:30] + WORLD_W'(px_reg);
        if (state_reg == ST_ROT && u_reg == 3'd6)
            wy_reg <= acc[ACC_W-1:30] + WORLD_W'(py_reg);
        if (state_reg == ST_MAP_DELTA || state_reg == ST_LMK_DELTA) begin
            dx_reg  <= dx_calc;
            dy_reg  <= dy_calc;
            oor_reg <= oor_calc;
        end
        if (state_reg == ST_MAP_MAC && u_reg == 3'd3)
            t0_reg <= sat_q16;
        if (state_reg == ST_MAP_MAC && u_reg == 3'd5)
            t1_reg <= sat_q16;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_class_reg;
    assign m_tdata  = {3'b0, out_dist_reg, out_index_reg};

    // checks
    a_new_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == CLASS_NEW) |-> (m_tdata == '0))
        else $error("new point result carries index or distance");

    a_map_gated: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == CLASS_MAP) |-> (m_tdata[36:6] < map_gate_reg))
        else $error("map match not under the map gate");

    a_lmk_gated: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == CLASS_LMK) |-> (m_tdata[36:6] < lmk_gate_reg))
        else $error("landmark match not under the landmark gate");

    a_map_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == CLASS_MAP) |-> (7'(m_tdata[5:0]) < n_map))
        else $error("map match index beyond searched count");

    a_busy_on_query: assert property (@(posedge aclk) disable iff (!aresetn)
        is_query |=> !s_tready)
        else $error("input taken while a query runs");

endmodule

/* bench/gated_nearest_landmark_match_test.sv */
// Self-checking testbench for the gated nearest landmark match block.
`timescale 1ns / 100ps

module gated_nearest_landmark_match_test;
    import gnlm_pkg::*;

    typedef logic signed [95:0] wide_t;

    typedef struct {
        class_t      cls;
        logic [5:0]  idx;
        logic [30:0] dist_sq;
    } match_t;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam wide_t      DIST_MAX    = 96'sd2147483647;
    localparam int         SETTLE      = 20;
    localparam longint     CYCLE_LIMIT = 3000000;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [279:0]  s_tdata = '0;
    logic [1:0]    s_tuser = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [39:0]   m_tdata;
    logic [1:0]    m_tuser;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    cfg_idx_t      cfg_index = CFG_MAP_COUNT;
    logic [30:0]   cfg_data = '0;

    gated_nearest_landmark_match dut (.*);

    always #5 aclk = ~aclk;

    // predictor state
    logic signed [31:0] map_x [64], map_y [64];
    logic signed [31:0] w_a [64], w_b [64], w_c [64], w_d [64];
    logic signed [31:0] lmk_x [64], lmk_y [64];
    logic [6:0]         map_cnt = 7'd0, lmk_cnt = 7'd0;
    logic [30:0]        map_gate = MAP_GATE_RST, lmk_gate = LMK_GATE_RST;

    match_t  pending_matches [$];
    int      mismatches = 0;
    int      tx_idle = 0, rx_idle = 0;
    bit      rx_hold = 1'b0;
    longint  cycles = 0;

    const wide_t atan_tab [16] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767
    };

    // point rotated by heading, Q16.16, without the pose offset
    task automatic rotate(input logic signed [31:0] ox, input logic signed [31:0] oy,
                          input logic signed [15:0] hd, output wide_t rx, output wide_t ry);
        wide_t z, x, y, sx, sy, wox, woy;
        bit flip;
        z = hd;
        z = z * 131072;
        x = CORDIC_X0;
        y = 0;
        wox = ox;
        woy = oy;
        flip = 1'b0;
        if (z > HALF_PI_Q30) begin
            z = z - PI_Q30;
            flip = 1'b1;
        end else if (z < -HALF_PI_Q30) begin
            z = z + PI_Q30;
            flip = 1'b1;
        end
        for (int i = 0; i < 16; i++) begin
            sx = y >>> i;
            sy = x >>> i;
            if (z >= 0) begin
                x = x - sx; y = y + sy; z = z - atan_tab[i];
            end else begin
                x = x + sx; y = y - sy; z = z + atan_tab[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        rx = (wox * x - woy * y) >>> 30;
        ry = (wox * y + woy * x) >>> 30;
    endtask

    function automatic bit delta_wild(wide_t dx, wide_t dy);
        return dx > DIST_MAX || dx < -DIST_MAX || dy > DIST_MAX || dy < -DIST_MAX;
    endfunction

    function automatic wide_t clip31(wide_t v);
        if (v > DIST_MAX) return DIST_MAX;
        if (v < -DIST_MAX) return -DIST_MAX;
        return v;
    endfunction

    function automatic wide_t weighted_dist(wide_t dx, wide_t dy, int j);
        wide_t a, b, c, d, t0, t1, q;
        a = w_a[j]; b = w_b[j]; c = w_c[j]; d = w_d[j];
        if (delta_wild(dx, dy)) return DIST_MAX;
        t0 = clip31((a * dx + c * dy) >>> 16);
        t1 = clip31((b * dx + d * dy) >>> 16);
        q = (dx * t0 + dy * t1) >>> 16;
        if (q < 0 || q > DIST_MAX) return DIST_MAX;
        return q;
    endfunction

    function automatic wide_t euclid_dist(wide_t dx, wide_t dy);
        wide_t q;
        if (delta_wild(dx, dy)) return DIST_MAX;
        q = (dx * dx + dy * dy) >>> 16;
        return (q > DIST_MAX) ? DIST_MAX : q;
    endfunction

    task automatic predict_match(input logic signed [31:0] ox, input logic signed [31:0] oy,
                                 input logic signed [31:0] px, input logic signed [31:0] py,
                                 input logic signed [15:0] hd, output match_t r);
        wide_t rx, ry, wx, wy, best, cand, wpx, wpy, ex, ey, gate;
        int n, best_j;
        rotate(ox, oy, hd, rx, ry);
        wpx = px;
        wpy = py;
        wx = rx + wpx;
        wy = ry + wpy;
        r.cls = CLASS_NEW; r.idx = '0; r.dist_sq = '0;
        n = (map_cnt > 64) ? 64 : map_cnt;
        if (n > 0) begin
            best = DIST_MAX; best_j = 0;
            for (int j = 0; j < n; j++) begin
                ex = map_x[j]; ey = map_y[j];
                cand = weighted_dist(ex - wx, ey - wy, j);
                if (cand < best) begin best = cand; best_j = j; end
            end
            gate = {65'b0, map_gate};
            if (best < gate) begin
                r.cls = CLASS_MAP; r.idx = best_j[5:0]; r.dist_sq = best[30:0];
                return;
            end
        end
        n = (lmk_cnt > 64) ? 64 : lmk_cnt;
        if (n > 0) begin
            best = DIST_MAX; best_j = 0;
            for (int j = 0; j < n; j++) begin
                ex = lmk_x[j]; ey = lmk_y[j];
                cand = euclid_dist(wx - ex, wy - ey);
                if (cand < best) begin best = cand; best_j = j; end
            end
            gate = {65'b0, lmk_gate};
            if (best < gate) begin
                r.cls = CLASS_LMK; r.idx = best_j[5:0]; r.dist_sq = best[30:0];
            end
        end
    endtask

    // entered and left at a falling edge; tvalid stays up for back-to-back words
    task automatic send_word(input logic [1:0] k, input logic [5:0] slot,
                             input logic signed [31:0] x, input logic signed [31:0] y,
                             input logic signed [31:0] a, input logic signed [31:0] b,
                             input logic signed [31:0] c, input logic signed [31:0] d,
                             input logic signed [31:0] px, input logic signed [31:0] py,
                             input logic signed [15:0] hd);
        match_t r;
        while ($urandom_range(99) < tx_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= {2'b0, hd, py, px, d, c, b, a, y, x, slot};
        do @(posedge aclk); while (!s_tready);
        case (k)
            KIND_MAP_WR: begin
                map_x[slot] = x; map_y[slot] = y;
                w_a[slot] = a; w_b[slot] = b; w_c[slot] = c; w_d[slot] = d;
            end
            KIND_LMK_WR: begin
                lmk_x[slot] = x; lmk_y[slot] = y;
            end
            KIND_QUERY: begin
                predict_match(x, y, px, py, hd, r);
                pending_matches.insert(pending_matches.size(), r);
            end
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_matches.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [30:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_MAP_COUNT: map_cnt = v[6:0];
            CFG_LMK_COUNT: lmk_cnt = v[6:0];
            CFG_MAP_GATE:  map_gate = v;
            CFG_LMK_GATE:  lmk_gate = v;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_regs(input logic [6:0] mc, input logic [6:0] lc,
                            input logic [30:0] mg, input logic [30:0] lg);
        settle();
        write_reg(CFG_MAP_COUNT, {24'b0, mc});
        write_reg(CFG_LMK_COUNT, {24'b0, lc});
        write_reg(CFG_MAP_GATE, mg);
        write_reg(CFG_LMK_GATE, lg);
    endtask

    function automatic logic signed [31:0] srand(int bits);
        logic signed [31:0] v;
        v = $urandom;
        return v >>> (32 - bits);
    endfunction

    task automatic map_entry(input logic [5:0] slot);
        send_word(KIND_MAP_WR, slot, srand(26), srand(26),
                  $urandom_range(1 << 18), srand(13), srand(13), $urandom_range(1 << 18),
                  $urandom, $urandom, 16'($urandom));
    endtask

    task automatic lmk_entry(input logic [5:0] slot);
        send_word(KIND_LMK_WR, slot, srand(26), srand(26), $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom, 16'($urandom));
    endtask

    // pose chosen so the observed point lands near a table entry
    task automatic aimed_query(input bit on_map, input int j, input int jitter_bits);
        logic signed [31:0] ox, oy, tx, ty;
        logic signed [15:0] hd;
        wide_t rx, ry, nx, ny;
        ox = srand(23);
        oy = srand(23);
        hd = 16'($urandom);
        tx = on_map ? map_x[j] : lmk_x[j];
        ty = on_map ? map_y[j] : lmk_y[j];
        rotate(ox, oy, hd, rx, ry);
        nx = (jitter_bits > 0) ? srand(jitter_bits) : 0;
        ny = (jitter_bits > 0) ? srand(jitter_bits) : 0;
        nx = tx - rx + nx;
        ny = ty - ry + ny;
        send_word(KIND_QUERY, 6'($urandom), ox, oy, $urandom, $urandom, $urandom, $urandom,
                  nx[31:0], ny[31:0], hd);
    endtask

    task automatic noise_word();
        send_word(2'($urandom), 6'($urandom), $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom, 16'($urandom));
    endtask

    // every entry is written before any count lets a query reach it
    task automatic test_fill_tables();
        for (int j = 0; j < 64; j++) map_entry(6'(j));
        for (int j = 0; j < 64; j++) lmk_entry(6'(j));
    endtask

    task automatic test_directed();
        logic signed [31:0] mn, mx;
        mn = 32'sh8000_0000;
        mx = 32'sh7FFF_FFFF;
        // empty tables: always a new point
        send_word(KIND_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        // duplicate entries at 3 and 7 for the lowest-index tie
        send_word(KIND_MAP_WR, 3, 32'sd65536, 32'sd131072, 32'sd65536, 0, 0,
                  32'sd65536, 0, 0, 0);
        send_word(KIND_MAP_WR, 7, 32'sd65536, 32'sd131072, 32'sd65536, 0, 0,
                  32'sd65536, 0, 0, 0);
        // weights not positive semidefinite
        send_word(KIND_MAP_WR, 9, 0, 0, -32'sd65536, 0, 0, -32'sd65536, 0, 0, 0);
        send_word(KIND_MAP_WR, 63, mx, mn, mx, mn, mn, mx, 0, 0, 0);
        send_word(KIND_LMK_WR, 63, mn, mx, 0, 0, 0, 0, 0, 0, 0);
        send_word(KIND_UNUSED, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        set_regs(7'd64, 7'd64, MAP_GATE_RST, LMK_GATE_RST);
        send_word(KIND_QUERY, 0, 0, 0, 0, 0, 0, 0, 32'sd65536, 32'sd131072, 0);
        send_word(KIND_QUERY, 0, 0, 0, 0, 0, 0, 0, 32'sd65537, 32'sd131072, 0);
        aimed_query(1'b0, 63, 0);
        aimed_query(1'b0, 20, 8);
        send_word(KIND_QUERY, 0, mx, mn, 0, 0, 0, 0, mn, mx, 16'sh7FFF);
        send_word(KIND_QUERY, 0, mn, mx, 0, 0, 0, 0, mx, mn, 16'sh8000);
        send_word(KIND_QUERY, 0, 32'sd65536, 0, 0, 0, 0, 0, 0, 0, 16'sd12868);
        send_word(KIND_QUERY, 0, 32'sd65536, 0, 0, 0, 0, 0, 0, 0, -16'sd12868);
        set_regs(7'd127, 7'd0, 31'd0, MAX_DIST);
        send_word(KIND_QUERY, 0, 0, 0, 0, 0, 0, 0, 32'sd65536, 32'sd131072, 0);
        aimed_query(1'b1, 40, 4);
        set_regs(7'd0, 7'd127, MAX_DIST, 31'd0);
        aimed_query(1'b0, 10, 0);
        set_regs(7'd1, 7'd1, MAX_DIST, MAX_DIST);
        send_word(KIND_QUERY, 0, mx, mx, 0, 0, 0, 0, mx, mx, 0);
    endtask

    task automatic random_phase(int items);
        int mc, lc, r, sent;
        logic [30:0] gates [4];
        sent = 0;
        while (sent < items) begin
            mc = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(8);
            lc = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(8);
            // full counts make long queries, keep them few
            if (mc > 16 && lc > 16) lc = 2;
            gates = '{MAP_GATE_RST, LMK_GATE_RST, 31'($urandom_range(1 << 22)), MAX_DIST};
            set_regs(7'(mc), 7'(lc),
                     gates[$urandom_range(3)] & ($urandom_range(5) == 0 ? 31'd0 : MAX_DIST),
                     gates[$urandom_range(3)]);
            repeat (40) begin
                r = $urandom_range(99);
                if (r < 15) map_entry(6'($urandom_range(15)));
                else if (r < 30) lmk_entry(6'($urandom_range(15)));
                else if (r < 55 && mc > 0)
                    aimed_query(1'b1, $urandom_range((mc > 64 ? 64 : mc) - 1),
                                $urandom_range(3) * 6);
                else if (r < 85 && lc > 0)
                    aimed_query(1'b0, $urandom_range((lc > 64 ? 64 : lc) - 1),
                                $urandom_range(4) * 5);
                else noise_word();
                sent++;
            end
        end
    endtask

    task automatic test_random();
        tx_idle = 11; rx_idle = 59;
        random_phase(200);
        tx_idle = 59; rx_idle = 11;
        random_phase(200);
        tx_idle = 0; rx_idle = 0;
        random_phase(200);
    endtask

    // receiver stays off long enough for the output register to fill and s_tready to drop
    task automatic test_backpressure();
        set_regs(7'd2, 7'd2, MAX_DIST, MAX_DIST);
        fork
            begin
                rx_hold = 1'b1;
                repeat (3000) @(negedge aclk);
                rx_hold = 1'b0;
            end
        join_none
        repeat (10) aimed_query(1'($urandom_range(1)), $urandom_range(1), 4);
    endtask

    always @(negedge aclk)
        m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle);

    always @(posedge aclk) begin
        match_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_matches.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word class %0d index %0d dist %0d",
                             m_tuser, m_tdata[5:0], m_tdata[36:6]);
            end else begin
                e = pending_matches.pop_front();
                if (m_tuser !== e.cls || m_tdata[5:0] !== e.idx ||
                    m_tdata[36:6] !== e.dist_sq) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: class %0d/%0d index %0d/%0d dist %0d/%0d (exp/got)",
                                 e.cls, m_tuser, e.idx, m_tdata[5:0], e.dist_sq,
                                 m_tdata[36:6]);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_fill_tables();
        test_directed();
        test_random();
        test_backpressure();
        settle();
        repeat (50) @(negedge aclk);
        if (mismatches == 0 && pending_matches.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
